[rtl/char_lcd_nibble_sequencer_top_defines.svh]
// Assertion macros used by the sequencer top.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, ignored while reset is high
`define CLN_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cln assertion failed");

// Next-cycle implication, ignored while reset is high
`define CLN_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cln assertion failed");

`else

`define CLN_ASSERT_IMP(label, clk, rst, ante, cons)
`define CLN_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/cln_pkg.sv]
package cln_pkg;

  // Request codes
  typedef enum logic [1:0] {
    ACT_INIT   = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_CURSOR = 2'd2,
    ACT_CHAR   = 2'd3
  } action_t;

  // Command bytes and init nibbles
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] ROW2_OFFSET    = 8'h40;
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_4BIT       = 4'h2;
  localparam logic [3:0] NIB_MASK       = 4'hF;

  // Idle times in microseconds
  localparam logic [15:0] POWER_UP_US  = 16'd50000;
  localparam logic [12:0] FIRST_GAP_US = 13'd5000;
  localparam logic [12:0] BYTE_GAP_US  = 13'd1000;
  localparam logic [12:0] CLEAR_GAP_US = 13'd3000;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Sequencer step counter and queue sizing
  localparam int STEP_W      = 4;
  localparam int WAKE_STEPS  = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Classified request handed from front to back
  typedef struct packed {
    logic       is_init;
    logic       reg_select;
    logic [7:0] data;
  } desc_t;

  // One nibble transfer
  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_before_us;
    logic [12:0] wait_after_us;
    logic        last;
  } nib_t;

  // Half of a byte: high nibble first, gap after the low nibble
  function automatic nib_t byte_nibble(input logic rs, input logic [7:0] b,
                                       input logic second, input logic fin);
    nib_t n;
    n.reg_select     = rs;
    n.wait_before_us = '0;
    n.last           = second & fin;
    if (second) begin
      n.nibble = b[3:0] & NIB_MASK;
      n.wait_after_us = (rs == RS_CMD && b == CMD_CLEAR) ? CLEAR_GAP_US : BYTE_GAP_US;
    end else begin
      n.nibble = b[7:4];
      n.wait_after_us = '0;
    end
    return n;
  endfunction

  // Command bytes sent after the wake-up nibbles
  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = CMD_FUNC_SET;
      2'd1: c = CMD_DISPLAY_ON;
      2'd2: c = CMD_CLEAR;
      default: c = CMD_ENTRY_MODE;
    endcase
    return c;
  endfunction

  // Power-up sequence, one nibble per step
  function automatic nib_t init_nibble(input logic [STEP_W-1:0] step);
    nib_t       n;
    logic [STEP_W-1:0] rel;
    rel = step - STEP_W'(WAKE_STEPS);
    n.reg_select     = RS_CMD;
    n.wait_before_us = '0;
    n.last           = 1'b0;
    unique case (step)
      4'd0: begin
        n.nibble = NIB_WAKE;
        n.wait_before_us = POWER_UP_US;
        n.wait_after_us = FIRST_GAP_US;
      end
      4'd1, 4'd2: begin
        n.nibble = NIB_WAKE;
        n.wait_after_us = BYTE_GAP_US;
      end
      4'd3: begin
        n.nibble = NIB_4BIT;
        n.wait_after_us = BYTE_GAP_US;
      end
      default: begin
        n = byte_nibble(RS_CMD, init_cmd(rel[2:1]), rel[0], rel[2:1] == 2'd3);
      end
    endcase
    return n;
  endfunction

endpackage

[rtl/cln_req_if.sv]
interface cln_req_if;
  import cln_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       row;
  logic [5:0] column;
  logic [7:0] char_code;

  modport source (output valid, action, row, column, char_code, input ready);
  modport sink   (input valid, action, row, column, char_code, output ready);
endinterface

[rtl/cln_res_if.sv]
interface cln_res_if;
  import cln_pkg::*;

  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [15:0] wait_before_us;
  logic [12:0] wait_after_us;
  logic        last;

  modport source (output valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                  input ready);
  modport sink   (input valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                  output ready);
endinterface

[rtl/char_lcd_nibble_sequencer_top.sv]
// Channel | Dir | Fields
// req     | in  | action, row, column, char_code
// res     | out | reg_select, nibble, wait_before_us, wait_after_us, last
//
// A byte request is one load and two nibbles in the back sequencer, init one load and
// twelve nibbles; the sequencer emits at most one nibble per cycle.
// A two-entry queue between the request decoder and the sequencer takes new requests
// while earlier ones are still being sent. rst is synchronous and clears queue, state and
// output valid. A stalled res holds the nibble and pauses the sequencer.
`include "char_lcd_nibble_sequencer_top_defines.svh"

module char_lcd_nibble_sequencer_top
  import cln_pkg::*;
(
  input logic       clk,
  input logic       rst,
  cln_req_if.sink   req,
  cln_res_if.source res
);

  logic  q_wr_valid;
  logic  q_wr_ready;
  desc_t q_wr_data;
  logic  q_rd_valid;
  logic  q_rd_ready;
  desc_t q_rd_data;

  cln_front u_front (
    .req        (req),
    .desc_valid (q_wr_valid),
    .desc_ready (q_wr_ready),
    .desc       (q_wr_data)
  );

  cln_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  cln_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (q_rd_valid),
    .desc_ready (q_rd_ready),
    .desc       (q_rd_data),
    .res        (res)
  );

  // A data nibble never carries a power-up wait and closes with the byte gap
  `CLN_ASSERT_IMP(a_data_no_wait, clk, rst, res.valid && res.reg_select, res.wait_before_us == '0)
  `CLN_ASSERT_IMP(a_data_gap, clk, rst, res.valid && res.reg_select && res.last, res.wait_after_us == BYTE_GAP_US)
  // Only the first wake-up nibble waits before it
  `CLN_ASSERT_IMP(a_power_up, clk, rst, res.valid && res.wait_before_us != '0, res.nibble == NIB_WAKE && !res.last)
  // A full queue cannot be empty on the next cycle
  `CLN_ASSERT_NXT(a_queue_full, clk, rst, q_wr_valid && !q_wr_ready, q_rd_valid)

endmodule

[rtl/cln_front.sv]
module cln_front
  import cln_pkg::*;
(
  cln_req_if.sink  req,
  output logic     desc_valid,
  input  logic     desc_ready,
  output desc_t    desc
);

  // Pass the handshake straight to the queue
  assign desc_valid = req.valid;
  assign req.ready  = desc_ready;

  // Classify the request into one byte or the init sequence
  always_comb begin
    desc.is_init    = 1'b0;
    desc.reg_select = RS_CMD;
    desc.data       = '0;
    unique case (action_t'(req.action))
      ACT_INIT: desc.is_init = 1'b1;
      ACT_CLEAR: desc.data = CMD_CLEAR;
      ACT_CURSOR: desc.data = CMD_SET_DDRAM | (req.row ? ROW2_OFFSET : 8'h00)
                              | {2'b00, req.column};
      default: begin
        desc.reg_select = RS_DATA;
        desc.data       = req.char_code;
      end
    endcase
  end

endmodule

[rtl/cln_queue.sv]
module cln_queue
  import cln_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  desc_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output desc_t rd_data
);

  desc_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign wr_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/cln_back.sv]
module cln_back
  import cln_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       desc_valid,
  output logic       desc_ready,
  input  desc_t      desc,
  cln_res_if.source  res
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t            state;
  desc_t             cur;
  logic [STEP_W-1:0] step;
  nib_t              nib;
  nib_t              out_nib;
  logic              out_valid;
  logic              advance;

  assign desc_ready = state == IDLE;
  assign advance    = state == RUN && (!out_valid || res.ready);

  // Pick the nibble for the current step
  always_comb begin
    if (cur.is_init) begin
      nib = init_nibble(step);
    end else begin
      nib = byte_nibble(cur.reg_select, cur.data, step[0], 1'b1);
    end
  end

  // Load a request, then emit one nibble per free output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // Raise valid on a new nibble, drop it once the transfer completes
      if (advance) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (desc_valid) begin
            cur   <= desc;
            step  <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          if (advance) begin
            out_nib <= nib;
            step    <= step + 1'b1;
            if (nib.last) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign res.valid          = out_valid;
  assign res.reg_select     = out_nib.reg_select;
  assign res.nibble         = out_nib.nibble;
  assign res.wait_before_us = out_nib.wait_before_us;
  assign res.wait_after_us  = out_nib.wait_after_us;
  assign res.last           = out_nib.last;

endmodule
